/* src/tsc_pkg.sv */
package tsc_pkg;

   localparam int CoordWidth = 16;
   localparam int MaxSegments = 1024;
   localparam int CountWidth = $clog2(MaxSegments);
   localparam int IndexWidth = 10;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type RegVertex1X = 3'd0;
   localparam csr_index_type RegVertex1Y = 3'd1;
   localparam csr_index_type RegVertex2X = 3'd2;
   localparam csr_index_type RegVertex2Y = 3'd3;
   localparam csr_index_type RegVertex3X = 3'd4;
   localparam csr_index_type RegVertex3Y = 3'd5;

   typedef enum logic [1:0] {
      ORIENT_COLLINEAR = 2'd0,
      ORIENT_CW        = 2'd1,
      ORIENT_CCW       = 2'd2
   } orient_type;

   typedef enum logic [1:0] {
      EDGE_V1V2 = 2'd0,
      EDGE_V1V3 = 2'd1,
      EDGE_V3V2 = 2'd2
   } edge_type;

endpackage

/* src/tsc_if.sv */
interface tsc_req_if;
   import tsc_pkg::*;

   logic      valid;
   logic      ready;
   coord_type seg_start_x;
   coord_type seg_start_y;
   coord_type seg_end_x;
   coord_type seg_end_y;
   logic      last_segment;

   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   last_segment, input ready);
   modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                 last_segment, output ready);
endinterface

interface tsc_rsp_if;
   import tsc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  crashed;
   logic [IndexWidth-1:0] hit_segment;
   logic [1:0]            hit_edge;

   modport source (output valid, crashed, hit_segment, hit_edge, input ready);
   modport sink (input valid, crashed, hit_segment, hit_edge, output ready);
endinterface

/* src/triangle_segment_collision_top.sv */
// Channel  Direction  Handshake      Payload
// req      in         valid/ready    seg_start_x/y, seg_end_x/y, last_segment
// rsp      out        valid/ready    crashed, hit_segment, hit_edge
// csr      in         write enable   csr_index, csr_wdata
//
// A request is taken every cycle unless a last request waits on a stalled response;
// its result passes through the input register, then the result register.
// Only requests marked last produce a response; the others update the query state.
// Reset is synchronous and clears all valid flags and the query state.
// A stalled response holds the result register; requests keep flowing until
// the next last request reaches the input register.
module triangle_segment_collision_top (
   input  logic                         clock,
   input  logic                         reset,
   tsc_req_if.sink                      req,
   tsc_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  tsc_pkg::csr_index_type       csr_index,
   input  logic [tsc_pkg::CsrDataWidth-1:0] csr_wdata
);
   import tsc_pkg::*;

   localparam int DiffWidth = CoordWidth + 1;
   localparam int ProdWidth = 2 * DiffWidth;
   localparam int CrossWidth = ProdWidth + 1;
   localparam count_type CountMax = CountWidth'(MaxSegments - 1);

   function automatic orient_type orient(input coord_type ax, input coord_type ay,
                                         input coord_type bx, input coord_type by,
                                         input coord_type cx, input coord_type cy);
      logic signed [DiffWidth-1:0]  dy1;
      logic signed [DiffWidth-1:0]  dx2;
      logic signed [DiffWidth-1:0]  dx1;
      logic signed [DiffWidth-1:0]  dy2;
      logic signed [ProdWidth-1:0]  p1;
      logic signed [ProdWidth-1:0]  p2;
      logic signed [CrossWidth-1:0] v;
      dy1 = DiffWidth'(by) - DiffWidth'(ay);
      dx2 = DiffWidth'(cx) - DiffWidth'(bx);
      dx1 = DiffWidth'(bx) - DiffWidth'(ax);
      dy2 = DiffWidth'(cy) - DiffWidth'(by);
      p1 = ProdWidth'(dy1) * ProdWidth'(dx2);
      p2 = ProdWidth'(dx1) * ProdWidth'(dy2);
      v = CrossWidth'(p1) - CrossWidth'(p2);
      if (v == '0) begin
         return ORIENT_COLLINEAR;
      end else if (v[CrossWidth-1]) begin
         return ORIENT_CCW;
      end else begin
         return ORIENT_CW;
      end
   endfunction

   function automatic logic in_box(input coord_type sx, input coord_type sy,
                                   input coord_type ex, input coord_type ey,
                                   input coord_type px, input coord_type py);
      logic x_ok;
      logic y_ok;
      x_ok = (sx < ex) ? (px >= sx && px <= ex) : (px >= ex && px <= sx);
      y_ok = (sy < ey) ? (py >= sy && py <= ey) : (py >= ey && py <= sy);
      return x_ok && y_ok;
   endfunction

   function automatic logic crosses(input coord_type a1x, input coord_type a1y,
                                    input coord_type a2x, input coord_type a2y,
                                    input coord_type b1x, input coord_type b1y,
                                    input coord_type b2x, input coord_type b2y);
      orient_type d1;
      orient_type d2;
      orient_type d3;
      orient_type d4;
      logic       hit;
      d1 = orient(a1x, a1y, a2x, a2y, b1x, b1y);
      d2 = orient(a1x, a1y, a2x, a2y, b2x, b2y);
      d3 = orient(b1x, b1y, b2x, b2y, a1x, a1y);
      d4 = orient(b1x, b1y, b2x, b2y, a2x, a2y);
      hit = (d1 != d2) && (d3 != d4);
      hit = hit || (d1 == ORIENT_COLLINEAR && in_box(a1x, a1y, a2x, a2y, b1x, b1y));
      hit = hit || (d2 == ORIENT_COLLINEAR && in_box(a1x, a1y, a2x, a2y, b2x, b2y));
      hit = hit || (d3 == ORIENT_COLLINEAR && in_box(b1x, b1y, b2x, b2y, a1x, a1y));
      hit = hit || (d4 == ORIENT_COLLINEAR && in_box(b1x, b1y, b2x, b2y, a2x, a2y));
      return hit;
   endfunction

   coord_type v1x_ff, v1y_ff, v2x_ff, v2y_ff, v3x_ff, v3y_ff;

   logic      s1_valid_ff;
   coord_type s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff;
   logic      s1_last_ff;

   logic [2:0] hit_vec;

   logic      hit_seen_ff;
   count_type first_hit_index_ff;
   edge_type  first_hit_edge_ff;
   count_type segment_count_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_crashed_ff;
   logic [IndexWidth-1:0] rsp_segment_ff;
   edge_type              rsp_edge_ff;

   logic      out_free;
   logic      s1_go;
   logic      req_take;
   logic      hit_now;
   logic      seen_in;
   count_type index_in;
   edge_type  edge_now;
   edge_type  edge_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1x_ff <= '0;
         v1y_ff <= '0;
         v2x_ff <= '0;
         v2y_ff <= '0;
         v3x_ff <= '0;
         v3y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            RegVertex1X: v1x_ff <= coord_type'(csr_wdata);
            RegVertex1Y: v1y_ff <= coord_type'(csr_wdata);
            RegVertex2X: v2x_ff <= coord_type'(csr_wdata);
            RegVertex2Y: v2y_ff <= coord_type'(csr_wdata);
            RegVertex3X: v3x_ff <= coord_type'(csr_wdata);
            RegVertex3Y: v3y_ff <= coord_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s1_go = s1_valid_ff && (!s1_last_ff || out_free);
   assign req.ready = !s1_valid_ff || s1_go;
   assign req_take = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sx_ff <= req.seg_start_x;
         s1_sy_ff <= req.seg_start_y;
         s1_ex_ff <= req.seg_end_x;
         s1_ey_ff <= req.seg_end_y;
         s1_last_ff <= req.last_segment;
      end
   end

   always_comb begin
      hit_vec[0] = crosses(s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff,
                           v1x_ff, v1y_ff, v2x_ff, v2y_ff);
      hit_vec[1] = crosses(s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff,
                           v1x_ff, v1y_ff, v3x_ff, v3y_ff);
      hit_vec[2] = crosses(s1_sx_ff, s1_sy_ff, s1_ex_ff, s1_ey_ff,
                           v3x_ff, v3y_ff, v2x_ff, v2y_ff);
   end

   always_comb begin
      hit_now = !hit_seen_ff && (hit_vec != 3'b000);
      if (hit_vec[0]) begin
         edge_now = EDGE_V1V2;
      end else if (hit_vec[1]) begin
         edge_now = EDGE_V1V3;
      end else begin
         edge_now = EDGE_V3V2;
      end
      seen_in = hit_seen_ff || hit_now;
      index_in = hit_now ? segment_count_ff : first_hit_index_ff;
      edge_in = hit_now ? edge_now : first_hit_edge_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_seen_ff <= 1'b0;
         first_hit_index_ff <= '0;
         first_hit_edge_ff <= EDGE_V1V2;
         segment_count_ff <= '0;
      end else if (s1_go) begin
         if (s1_last_ff) begin
            hit_seen_ff <= 1'b0;
            first_hit_index_ff <= '0;
            first_hit_edge_ff <= EDGE_V1V2;
            segment_count_ff <= '0;
         end else begin
            hit_seen_ff <= seen_in;
            first_hit_index_ff <= index_in;
            first_hit_edge_ff <= edge_in;
            if (segment_count_ff != CountMax) begin
               segment_count_ff <= segment_count_ff + count_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_go && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         rsp_crashed_ff <= seen_in;
         rsp_segment_ff <= IndexWidth'(index_in);
         rsp_edge_ff <= edge_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.crashed = rsp_crashed_ff;
   assign rsp.hit_segment = rsp_segment_ff;
   assign rsp.hit_edge = rsp_edge_ff;

endmodule
